@@ sv/assert_macros.svh @@
// Assertion helpers for the gradient block's RTL. Every property is sampled on the
// rising edge of aclk and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDGM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDGM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cdgm_pkg.sv @@
package cdgm_pkg;

    // Largest frame width the line stores can hold.
    localparam int MAX_WIDTH = 2048;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int ROW_W  = 12;
    localparam int MAG_W  = 9;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);

    // Sum of two squared 8-bit differences.
    localparam int SQ_W       = 2 * PIX_W + 1;
    localparam int SQRT_STEPS = (SQ_W + 1) / 2;
    localparam int OP_W       = 2 * SQRT_STEPS;
    localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CALC,
        ST_ROOT,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    // Status of the square-root unit as seen by the sequencer.
    typedef struct packed {
        logic             busy;
        logic [MAG_W-1:0] root;
    } cdgm_root_stat_t;

endpackage

@@ sv/cdgm_ram.sv @@
module cdgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/cdgm_isqrt.sv @@
module cdgm_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cdgm_pkg::SQ_W-1:0]     operand,
    output cdgm_pkg::cdgm_root_stat_t     stat
);

    // Restoring square root, one result bit per cycle, two operand bits brought
    // down each step.
    logic [cdgm_pkg::CNT_W-1:0]   cnt_reg;
    logic [cdgm_pkg::OP_W-1:0]    op_reg;
    logic [cdgm_pkg::MAG_W:0]     rem_reg;
    logic [cdgm_pkg::MAG_W-1:0]   root_reg;

    logic [cdgm_pkg::MAG_W+2:0]   rem_sh;
    logic [cdgm_pkg::MAG_W+2:0]   trial;
    logic [cdgm_pkg::MAG_W+2:0]   rem_diff;
    logic                         take;
    logic                         busy;

    assign busy = (cnt_reg != '0);

    always_comb begin
        rem_sh   = {rem_reg, op_reg[cdgm_pkg::OP_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        take     = (rem_sh >= trial);
        rem_diff = rem_sh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= cdgm_pkg::CNT_W'(cdgm_pkg::SQRT_STEPS);
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg   <= cdgm_pkg::OP_W'(operand);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy) begin
            op_reg   <= op_reg << 2;
            rem_reg  <= take ? rem_diff[cdgm_pkg::MAG_W:0] : rem_sh[cdgm_pkg::MAG_W:0];
            root_reg <= {root_reg[cdgm_pkg::MAG_W-2:0], take};
        end
    end

    assign stat.busy = busy;
    assign stat.root = root_reg;

endmodule

@@ sv/central_difference_gradient_magnitude.sv @@
// Central-difference gradient magnitude over a raster stream of 8-bit grey
// pixels. For every interior pixel the block returns floor(sqrt(dx*dx + dy*dy))
// on 9 bits (0 to 360), with dx the difference of the right and left neighbours
// and dy that of the lower and upper ones; pixels on the frame border return 0.
// Results leave in raster order one row behind the input: a pixel in row 0
// returns its own zero at once, a pixel in row 2 or later returns the result
// for the pixel above it, and a pixel in the last row also returns its own
// zero. A pixel of row 1 that is not in the last row returns nothing. The flag
// last_of_run marks the final result that one input causes, and frame_done
// marks the result for the frame's last pixel. Frame width (register 0) is
// clamped to 1..2048 and frame height (register 1) to at least 1; both should
// be written only while the block is idle. The previous two rows sit in two
// synchronous line stores that need no clearing after reset. The block works
// on one pixel at a time: the time for an interior pixel is set by the two
// sequential reads of the upper line store and the nine-step square-root
// unit, and that for any other pixel by how many results it causes. A result
// that is not taken holds the sequencer in its emit state, which stretches
// these times. The result register lets the next pixel enter while a result
// waits to be taken.
`include "assert_macros.svh"

module central_difference_gradient_magnitude (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [cdgm_pkg::PIX_W-1:0]         s_pixel,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [cdgm_pkg::MAG_W-1:0]         m_magnitude,
    output logic                               m_last_of_run,
    output logic                               m_frame_done,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cdgm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdgm_pkg::CFG_W-1:0]         cfg_data
);

    // Configuration registers.
    logic [cdgm_pkg::CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [cdgm_pkg::CFG_W-1:0] frame_height_reg, frame_height_next;

    // Sequencer and position state.
    cdgm_pkg::state_t state_reg, state_next;
    logic [cdgm_pkg::COL_W-1:0] col_count_reg, col_count_next;
    logic [cdgm_pkg::ROW_W-1:0] row_count_reg, row_count_next;
    logic [cdgm_pkg::PIX_W-1:0] left_reg, left_next;

    // Per-transaction working registers.
    logic [cdgm_pkg::PIX_W-1:0] px_reg;
    logic [cdgm_pkg::COL_W-1:0] col_reg;
    logic                       need_a_reg;
    logic                       need_b_reg;
    logic                       interior_reg;
    logic                       last_row_reg;
    logic                       done_b_reg;
    logic [cdgm_pkg::PIX_W-1:0] above_reg;
    logic [cdgm_pkg::PIX_W-1:0] ady_reg;

    // Result register.
    logic                       m_valid_reg, m_valid_next;
    logic [cdgm_pkg::MAG_W-1:0] m_magnitude_reg;
    logic                       m_last_of_run_reg;
    logic                       m_frame_done_reg;

    // Effective frame size and clamped position of the incoming pixel.
    logic [cdgm_pkg::WEFF_W-1:0] w_eff;
    logic [cdgm_pkg::ROW_W-1:0]  h_eff;
    logic [cdgm_pkg::COL_W-1:0]  col_cl;
    logic [cdgm_pkg::ROW_W-1:0]  row_cl;
    logic [cdgm_pkg::WEFF_W-1:0] col_p1;
    logic                        last_col;
    logic                        last_row;
    logic                        interior;

    // Sequencer outputs.
    logic accept;
    logic fetch_we;
    logic root_start;
    logic load_a;
    logic load_b;
    logic out_free;

    // Line stores.
    logic [cdgm_pkg::COL_W-1:0] rd_addr;
    logic [cdgm_pkg::PIX_W-1:0] above_rd;
    logic [cdgm_pkg::PIX_W-1:0] two_rd;

    // Datapath.
    logic [cdgm_pkg::PIX_W-1:0]   ady;
    logic [cdgm_pkg::PIX_W-1:0]   adx;
    logic [2*cdgm_pkg::PIX_W-1:0] adx_sq;
    logic [2*cdgm_pkg::PIX_W-1:0] ady_sq;
    logic [cdgm_pkg::SQ_W-1:0]    sum_sq;
    cdgm_pkg::cdgm_root_stat_t    root_stat;

    // ------------------------------------------------------------------
    // Configuration port. Writes are always taken.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                cdgm_pkg::CFG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                cdgm_pkg::CFG_FRAME_HEIGHT: frame_height_next = cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame geometry. A zero size acts as one, and a width beyond the line
    // store acts as its full depth. A counter left beyond a smaller frame is
    // pulled back to the last column or row before it is used.
    // ------------------------------------------------------------------
    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = cdgm_pkg::WEFF_W'(1);
        end else if (int'(frame_width_reg) > cdgm_pkg::MAX_WIDTH) begin
            w_eff = cdgm_pkg::WEFF_W'(cdgm_pkg::MAX_WIDTH);
        end else begin
            w_eff = cdgm_pkg::WEFF_W'(frame_width_reg);
        end

        h_eff = (frame_height_reg == '0) ? cdgm_pkg::ROW_W'(1) : frame_height_reg;

        if (cdgm_pkg::WEFF_W'(col_count_reg) >= w_eff) begin
            col_cl = cdgm_pkg::COL_W'(w_eff - 1'b1);
        end else begin
            col_cl = col_count_reg;
        end

        if (row_count_reg >= h_eff) begin
            row_cl = h_eff - 1'b1;
        end else begin
            row_cl = row_count_reg;
        end

        col_p1   = cdgm_pkg::WEFF_W'(col_cl) + 1'b1;
        last_col = (col_p1 == w_eff);
        last_row = (row_cl == h_eff - 1'b1);
        interior = (col_cl != '0) && (col_p1 < w_eff);
    end

    // Position counters advance as soon as a pixel is accepted; they wrap to
    // the top-left corner after the frame's last pixel.
    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept) begin
            if (last_col) begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : row_cl + 1'b1;
            end else begin
                col_count_next = col_p1[cdgm_pkg::COL_W-1:0];
                row_count_next = row_cl;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. The accept cycle reads both stores at the pixel's column,
    // the fetch cycle writes the column back and reads the upper store one
    // column to the right, and the calculation cycle forms the sum of squares.
    // Each pixel finishes its write-back before the next one is accepted, so
    // the stores never see a read and a write of one entry in flight at once.
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cdgm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = cdgm_pkg::ST_FETCH;
                end
            end
            cdgm_pkg::ST_FETCH: begin
                state_next = cdgm_pkg::ST_CALC;
            end
            cdgm_pkg::ST_CALC: begin
                if (need_a_reg) begin
                    state_next = interior_reg ? cdgm_pkg::ST_ROOT : cdgm_pkg::ST_EMIT_A;
                end else if (need_b_reg) begin
                    state_next = cdgm_pkg::ST_EMIT_B;
                end else begin
                    state_next = cdgm_pkg::ST_IDLE;
                end
            end
            cdgm_pkg::ST_ROOT: begin
                if (!root_stat.busy) begin
                    state_next = cdgm_pkg::ST_EMIT_A;
                end
            end
            cdgm_pkg::ST_EMIT_A: begin
                if (out_free) begin
                    state_next = need_b_reg ? cdgm_pkg::ST_EMIT_B : cdgm_pkg::ST_IDLE;
                end
            end
            cdgm_pkg::ST_EMIT_B: begin
                if (out_free) begin
                    state_next = cdgm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cdgm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        fetch_we   = 1'b0;
        root_start = 1'b0;
        load_a     = 1'b0;
        load_b     = 1'b0;
        unique case (state_reg)
            cdgm_pkg::ST_IDLE:   s_ready    = 1'b1;
            cdgm_pkg::ST_FETCH:  fetch_we   = 1'b1;
            cdgm_pkg::ST_CALC:   root_start = need_a_reg && interior_reg;
            cdgm_pkg::ST_ROOT:   ;
            cdgm_pkg::ST_EMIT_A: load_a     = out_free;
            cdgm_pkg::ST_EMIT_B: load_b     = out_free;
            default:             ;
        endcase
    end

    assign accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Line stores. The upper row sits in one store and the row above that in
    // the other; the write-back shifts the column down by one row.
    // ------------------------------------------------------------------
    assign rd_addr = (state_reg == cdgm_pkg::ST_FETCH) ? col_reg + cdgm_pkg::COL_W'(1) : col_cl;

    cdgm_ram #(
        .WIDTH (cdgm_pkg::PIX_W),
        .DEPTH (cdgm_pkg::MAX_WIDTH)
    ) u_row_above (
        .aclk    (aclk),
        .wr_en   (fetch_we),
        .wr_addr (col_reg),
        .wr_data (px_reg),
        .rd_addr (rd_addr),
        .rd_data (above_rd)
    );

    cdgm_ram #(
        .WIDTH (cdgm_pkg::PIX_W),
        .DEPTH (cdgm_pkg::MAX_WIDTH)
    ) u_row_two_above (
        .aclk    (aclk),
        .wr_en   (fetch_we),
        .wr_addr (col_reg),
        .wr_data (above_rd),
        .rd_addr (rd_addr),
        .rd_data (two_rd)
    );

    // ------------------------------------------------------------------
    // Differences and squares. dy is ready in the fetch cycle; dx needs the
    // right neighbour, which arrives in the calculation cycle, and the left
    // neighbour still holds the previous column of the upper row then.
    // ------------------------------------------------------------------
    always_comb begin
        ady    = (px_reg >= two_rd) ? px_reg - two_rd : two_rd - px_reg;
        adx    = (above_rd >= left_reg) ? above_rd - left_reg : left_reg - above_rd;
        adx_sq = adx * adx;
        ady_sq = ady_reg * ady_reg;
        sum_sq = {1'b0, adx_sq} + {1'b0, ady_sq};
    end

    always_comb begin
        left_next = left_reg;
        if (state_reg == cdgm_pkg::ST_CALC) begin
            left_next = above_reg;
        end
    end

    cdgm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .operand (sum_sq),
        .stat    (root_stat)
    );

    // ------------------------------------------------------------------
    // Result register. It parts the result channel from the sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        if (load_a || load_b) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= cdgm_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= cdgm_pkg::FRAME_HEIGHT_RESET;
            state_reg        <= cdgm_pkg::ST_IDLE;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            left_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            state_reg        <= state_next;
            col_count_reg    <= col_count_next;
            row_count_reg    <= row_count_next;
            left_reg         <= left_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg       <= s_pixel;
            col_reg      <= col_cl;
            need_a_reg   <= (row_cl >= cdgm_pkg::ROW_W'(2));
            need_b_reg   <= (row_cl == '0) || last_row;
            interior_reg <= interior;
            last_row_reg <= last_row;
            done_b_reg   <= last_row && last_col;
        end
        if (state_reg == cdgm_pkg::ST_FETCH) begin
            above_reg <= above_rd;
            ady_reg   <= ady;
        end
        if (load_a) begin
            m_magnitude_reg   <= interior_reg ? root_stat.root : '0;
            m_last_of_run_reg <= !last_row_reg;
            m_frame_done_reg  <= 1'b0;
        end else if (load_b) begin
            m_magnitude_reg   <= '0;
            m_last_of_run_reg <= 1'b1;
            m_frame_done_reg  <= done_b_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_magnitude   = m_magnitude_reg;
    assign m_last_of_run = m_last_of_run_reg;
    assign m_frame_done  = m_frame_done_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CDGM_ASSERT_NXT(a_one_in_flight, s_valid && s_ready, !s_ready, "pixel accepted while busy")
    `CDGM_ASSERT_IMP(a_done_is_last, m_valid && m_frame_done, m_last_of_run, "done without last")
    `CDGM_ASSERT_IMP(a_root_in_root_state, root_stat.busy, state_reg == cdgm_pkg::ST_ROOT, "stray root")
    `CDGM_ASSERT_NXT(a_emit_holds, state_reg == cdgm_pkg::ST_EMIT_A && m_valid && !m_ready, state_reg == cdgm_pkg::ST_EMIT_A, "result dropped while output stalled")

endmodule

@@ sim/cdgm_gradient_checker.sv @@
`timescale 1ns / 100ps

// Watches the pixel, result and register channels of the gradient block. It keeps
// its own copy of the line stores and counters, and it queues the results that each
// accepted pixel must cause. Each accepted result is compared with the oldest entry.
module cdgm_gradient_checker (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [cdgm_pkg::PIX_W-1:0]     s_pixel,

    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [cdgm_pkg::MAG_W-1:0]     m_magnitude,
    input  logic                           m_last_of_run,
    input  logic                           m_frame_done,

    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [cdgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdgm_pkg::CFG_W-1:0]     cfg_data,

    output int                             fail_count,
    output int                             outstanding,
    output int                             results_checked,
    output int                             nonzero_results,
    output int                             peak_magnitude
);

    typedef struct packed {
        logic [cdgm_pkg::MAG_W-1:0] magnitude;
        logic                       last_of_run;
        logic                       frame_done;
    } gradient_t;

    logic [cdgm_pkg::CFG_W-1:0] width_reg;
    logic [cdgm_pkg::CFG_W-1:0] height_reg;
    logic [cdgm_pkg::PIX_W-1:0] line_above     [cdgm_pkg::MAX_WIDTH];
    logic [cdgm_pkg::PIX_W-1:0] line_two_above [cdgm_pkg::MAX_WIDTH];
    logic [cdgm_pkg::PIX_W-1:0] left_pix;
    int unsigned                col_pos;
    int unsigned                row_pos;
    gradient_t                  pending_gradients [$];

    // Bitwise search for the largest root whose square does not exceed the sum.
    function automatic logic [cdgm_pkg::MAG_W-1:0] floor_root(input int unsigned sum);
        int unsigned root;
        int unsigned trial;
        int          b;
        root = 0;
        for (b = cdgm_pkg::MAG_W - 1; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= sum) begin
                root = trial;
            end
        end
        return root[cdgm_pkg::MAG_W-1:0];
    endfunction

    // Queues what one pixel causes, then advances the stores and the counters.
    function automatic void predict_gradient(input logic [cdgm_pkg::PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          dx;
        int          dy;
        logic [cdgm_pkg::PIX_W-1:0] above;
        logic        bottom_row;
        gradient_t   want;
        w = (width_reg == 0) ? 1 :
            ((width_reg > cdgm_pkg::MAX_WIDTH) ? cdgm_pkg::MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        bottom_row = (r == h - 1);
        above = line_above[c];

        if (r >= 2) begin
            want.magnitude = '0;
            if (c >= 1 && c + 1 < w) begin
                dx = int'(line_above[c + 1]) - int'(left_pix);
                dy = int'(px) - int'(line_two_above[c]);
                want.magnitude = floor_root(dx * dx + dy * dy);
            end
            want.last_of_run = !bottom_row;
            want.frame_done  = 1'b0;
            pending_gradients = {pending_gradients, want};
        end
        if (r == 0 || bottom_row) begin
            want.magnitude   = '0;
            want.last_of_run = 1'b1;
            want.frame_done  = bottom_row && (c == w - 1);
            pending_gradients = {pending_gradients, want};
        end

        left_pix          = above;
        line_two_above[c] = above;
        line_above[c]     = px;

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endfunction

    always @(posedge aclk) begin : monitor
        gradient_t want;
        int        k;
        if (!aresetn) begin
            width_reg  = cdgm_pkg::FRAME_WIDTH_RESET;
            height_reg = cdgm_pkg::FRAME_HEIGHT_RESET;
            for (k = 0; k < cdgm_pkg::MAX_WIDTH; k++) begin
                line_above[k]     = '0;
                line_two_above[k] = '0;
            end
            left_pix        = '0;
            col_pos         = 0;
            row_pos         = 0;
            fail_count      = 0;
            results_checked = 0;
            nonzero_results = 0;
            peak_magnitude  = 0;
            pending_gradients.delete();
        end else begin
            // Results are checked before this edge's pixel is queued; a pixel
            // cannot produce its result in the cycle it is accepted.
            if (m_valid && m_ready) begin
                results_checked++;
                if (pending_gradients.size() == 0) begin
                    $error("result with no pixel behind it: magnitude %0d last_of_run %0b",
                           m_magnitude, m_last_of_run);
                    fail_count++;
                end else begin
                    want = pending_gradients.pop_front();
                    if (m_magnitude !== want.magnitude) begin
                        $error("magnitude: expected %0d, got %0d", want.magnitude, m_magnitude);
                        fail_count++;
                    end
                    if (m_last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, m_last_of_run);
                        fail_count++;
                    end
                    if (m_frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0b, got %0b",
                               want.frame_done, m_frame_done);
                        fail_count++;
                    end
                end
                if (m_magnitude != 0) begin
                    nonzero_results++;
                end
                if (m_magnitude > peak_magnitude) begin
                    peak_magnitude = m_magnitude;
                end
            end
            // A pixel taken at this edge still sees the old frame size; a register
            // written at the same edge counts only from the next pixel on.
            if (s_valid && s_ready) begin
                predict_gradient(s_pixel);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == cdgm_pkg::CFG_FRAME_WIDTH) begin
                    width_reg = cfg_data;
                end else if (cfg_index == cdgm_pkg::CFG_FRAME_HEIGHT) begin
                    height_reg = cfg_data;
                end
            end
        end
        outstanding <= pending_gradients.size();
    end

endmodule

@@ sim/central_difference_gradient_magnitude_tb.sv @@
`timescale 1ns / 100ps

// Top of the gradient block's testbench. This module only makes stimulus and gives
// the verdict; the checker beside the block predicts every result and compares.
module central_difference_gradient_magnitude_tb;

    localparam int RESET_CYCLES  = 9;
    // Wait after the last expected result has been taken, long enough for any pixel
    // that is still inside the block to leave it.
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 550;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    // Two 3x3 frames whose center pixel reaches the largest magnitude, once with
    // rising and once with falling differences. Pixels are listed in raster order.
    localparam logic [71:0] CROSS_RISING  = {8'd10, 8'd0, 8'd20,
                                             8'd0, 8'd77, 8'd255,
                                             8'd30, 8'd255, 8'd40};
    localparam logic [71:0] CROSS_FALLING = {8'd0, 8'd255, 8'd0,
                                             8'd255, 8'd128, 8'd0,
                                             8'd0, 8'd0, 8'd255};

    typedef enum int {
        TEX_NOISE,
        TEX_BINARY,
        TEX_RAMP,
        TEX_FLAT
    } texture_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic [cdgm_pkg::PIX_W-1:0]     s_pixel   = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic [cdgm_pkg::MAG_W-1:0]     m_magnitude;
    logic                           m_last_of_run;
    logic                           m_frame_done;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [cdgm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cdgm_pkg::CFG_W-1:0]     cfg_data  = '0;

    int fail_count;
    int outstanding;
    int results_checked;
    int nonzero_results;
    int peak_magnitude;

    int pixels_sent    = 0;
    int settings_used  = 0;
    int cycle_count    = 0;
    // When set, the sender offers pixels back to back with no gaps.
    bit src_quiet      = 1'b0;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    int hold_requests  = 0;

    // Receiver state, owned by the receiver process alone.
    int hold_seen      = 0;
    int hold_left      = 0;
    int stall_left     = 0;
    int mode_left      = 0;
    bit sink_quiet     = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    central_difference_gradient_magnitude u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_magnitude   (m_magnitude),
        .m_last_of_run (m_last_of_run),
        .m_frame_done  (m_frame_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    cdgm_gradient_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_magnitude     (m_magnitude),
        .m_last_of_run   (m_last_of_run),
        .m_frame_done    (m_frame_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .nonzero_results (nonzero_results),
        .peak_magnitude  (peak_magnitude)
    );

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Picture content: noise, hard black and white, a wrapping ramp, or a nearly
    // flat area where magnitudes stay small.
    function automatic logic [cdgm_pkg::PIX_W-1:0] frame_pixel(input texture_t tex,
                                                               input int col,
                                                               input int row);
        logic [cdgm_pkg::PIX_W-1:0] px;
        case (tex)
            TEX_BINARY: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            TEX_RAMP:   px = cdgm_pkg::PIX_W'(col * 29 + row * 71);
            TEX_FLAT:   px = cdgm_pkg::PIX_W'(120 + $urandom_range(0, 15));
            default:    px = cdgm_pkg::PIX_W'($urandom_range(0, 255));
        endcase
        return px;
    endfunction

    // The receiver. Every falling edge it decides m_ready for the next cycle. A
    // hold-off request from the stimulus keeps m_ready low until a countdown loaded
    // from HOLD_CYCLES runs out here. Otherwise it alternates between stretches with random
    // stalls and stretches where it takes every result at once.
    always @(negedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            mode_left  = $urandom_range(50, 300);
            sink_quiet = ($urandom_range(0, 2) == 0);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!sink_quiet && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() + 1;
            end
        end
    end

    // Watchdog: a run that stops making progress ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("central_difference_gradient_magnitude_tb NOT OK");
            $finish;
        end
    end

    // Offers one pixel and returns at the falling edge after the transaction.
    // Valid stays high into the next call unless that call opens a gap.
    task automatic send_pixel(input logic [cdgm_pkg::PIX_W-1:0] px);
        int gap;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // Sends count pixels of a picture that is w pixels wide, in raster order.
    task automatic send_run(input int count, input int w, input texture_t tex);
        int i;
        for (i = 0; i < count; i++) begin
            send_pixel(frame_pixel(tex, i % w, i / w));
        end
    endtask

    // Stops offering pixels and waits until every expected result has been taken
    // and any pixel that causes no result has left the block.
    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [cdgm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cdgm_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Register writes happen only once the block is idle.
    task automatic write_regs(input bit set_w, input int w, input bit set_h, input int h);
        drain();
        if (set_w) begin
            cfg_write(cdgm_pkg::CFG_FRAME_WIDTH, w[cdgm_pkg::CFG_W-1:0]);
        end
        if (set_h) begin
            cfg_write(cdgm_pkg::CFG_FRAME_HEIGHT, h[cdgm_pkg::CFG_W-1:0]);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // A frame that is broken off part way: after a few pixels the width shrinks
    // or the height moves, so the counters get clamped, and a single pixel at
    // 1x1 then brings the counters back to the top left corner. The width never
    // grows in the middle of a frame, since that would read line store entries
    // that hold nothing of the current frame. A very wide frame gets only a
    // short second run so that the item count stays near its target.
    task automatic odd_frame(input int w0, input int h0);
        int eff_w;
        int w1;
        write_regs(1'b1, w0, 1'b1, h0);
        eff_w = (w0 == 0) ? 1 : ((w0 > cdgm_pkg::MAX_WIDTH) ? cdgm_pkg::MAX_WIDTH : w0);
        send_run($urandom_range(1, 40), eff_w, TEX_NOISE);
        if (eff_w > 1 && $urandom_range(0, 1) == 1) begin
            w1 = $urandom_range(1, (eff_w - 1 < 12) ? eff_w - 1 : 12);
            write_regs(1'b1, w1, 1'b0, 0);
            eff_w = w1;
        end else begin
            write_regs(1'b0, 0, 1'b1, $urandom_range(0, 10));
        end
        send_run($urandom_range(0, (eff_w < 16) ? 3 * eff_w : 48), eff_w, TEX_BINARY);
        write_regs(1'b1, $urandom_range(0, 1), 1'b1, $urandom_range(0, 1));
        send_pixel(cdgm_pkg::PIX_W'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        int       i;
        int       roll;
        int       fw;
        int       fh;
        int       rows;
        int       random_start;
        texture_t tex;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. The smallest frame with an interior, driven to the
        // largest magnitude with both signs of the differences.
        write_regs(1'b1, 3, 1'b1, 3);
        for (i = 0; i < 9; i++) begin
            send_pixel(CROSS_RISING[8 * (8 - i) +: 8]);
        end
        for (i = 0; i < 9; i++) begin
            send_pixel(CROSS_FALLING[8 * (8 - i) +: 8]);
        end

        // Zero for both sizes acts as 1x1: each pixel ends its own frame.
        write_regs(1'b1, 0, 1'b1, 0);
        send_pixel(8'hFF);
        send_pixel(8'h00);

        // A width above the store size acts as the store size, here with a
        // single row so that every pixel returns its own zero.
        write_regs(1'b1, 4095, 1'b1, 1);
        send_pixel(8'h5A);
        send_pixel(8'hA5);
        send_pixel(8'hFF);

        // Shrinking the width in the middle of a row clamps the column; the
        // three pixels that follow end a 2x2 frame and leave the counters at zero.
        write_regs(1'b1, 2, 1'b1, 2);
        send_pixel(8'h01);
        send_pixel(8'h80);
        send_pixel(8'h7F);

        // Random part. The first frame runs against a long receiver hold-off
        // while pixels come back to back, so the block fills and stalls its input.
        random_start = pixels_sent;
        write_regs(1'b1, 16, 1'b1, 12);
        src_quiet = 1'b1;
        hold_requests <= hold_requests + 1;
        send_run(16 * 12, 16, TEX_NOISE);
        src_quiet = 1'b0;

        // The largest width and height, left part way through the first row.
        odd_frame(cdgm_pkg::MAX_WIDTH, 4095);

        while (pixels_sent - random_start < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            tex = texture_t'($urandom_range(0, 3));
            src_quiet = ($urandom_range(0, 3) == 0);
            if (roll < 75) begin
                // A whole frame of random size, mostly small.
                roll = $urandom_range(0, 99);
                fw = (roll < 70) ? $urandom_range(1, 8) :
                     (roll < 95) ? $urandom_range(9, 24) : $urandom_range(25, 64);
                fh = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) :
                                                     $urandom_range(7, 12);
                write_regs(1'b1, fw, 1'b1, fh);
                send_run(fw * fh, fw, tex);
            end else if (roll < 88) begin
                odd_frame($urandom_range(1, 16), $urandom_range(1, 8));
            end else begin
                // The tallest frame, cut short by lowering the height so that
                // the next row becomes the last one.
                fw = $urandom_range(3, 6);
                rows = $urandom_range(2, 4);
                write_regs(1'b1, fw, 1'b1, 4095);
                send_run(rows * fw, fw, tex);
                write_regs(1'b0, 0, 1'b1, rows + 1);
                send_run(fw, fw, tex);
            end
        end
        src_quiet = 1'b0;

        drain();
        $display("Sent %0d pixel transactions under %0d register settings, widths 1 to %0d.",
                 pixels_sent, settings_used, cdgm_pkg::MAX_WIDTH);
        $display("Checked %0d results, %0d of them nonzero, largest magnitude %0d.",
                 results_checked, nonzero_results, peak_magnitude);
        if (fail_count == 0) begin
            $display("central_difference_gradient_magnitude_tb OK");
        end else begin
            $display("central_difference_gradient_magnitude_tb NOT OK");
        end
        $finish;
    end

endmodule
